[rtl/core/rpn_pkg.sv]
`timescale 1ns / 1ps

package rpn_pkg;

    localparam int WORD_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int DEPTH_W = 5;

    localparam logic [FUNC_W-1:0] FN_PUSH = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SUB  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_MUL  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DIV  = 3'd4;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNKNOWN = 3'd1,
        ST_FULL    = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_DIVZERO = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_CALC,
        CS_FINISH
    } ctl_state_t;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [WORD_W-1:0] number;
    } cmd_item_t;

    typedef struct packed {
        status_t                  status;
        logic signed [WORD_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
    } rsp_item_t;

    // per-cell update: load wins, then shift toward bottom, then toward top
    typedef struct packed {
        logic load;
        logic shift_down;
        logic shift_up;
    } cell_ctrl_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } md_req_t;

endpackage

[rtl/core/rpn_cell.sv]
`timescale 1ns / 1ps

module rpn_cell
    import rpn_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [WORD_W-1:0] from_above,
    input  logic [WORD_W-1:0] from_below,
    input  logic [WORD_W-1:0] load_value,
    output logic [WORD_W-1:0] value
);

    logic [WORD_W-1:0] value_reg;
    logic [WORD_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load)
        begin
            value_next = load_value;
        end
        else if (ctrl.shift_down)
        begin
            value_next = from_above;
        end
        else if (ctrl.shift_up)
        begin
            value_next = from_below;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

[rtl/core/rpn_muldiv.sv]
`timescale 1ns / 1ps

module rpn_muldiv
    import rpn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  md_req_t           req,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic              done,
    output logic [WORD_W-1:0] result
);

    localparam int CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             is_div_reg;
    logic             neg_reg;
    logic [WORD_W-1:0] acc_reg;
    logic [WORD_W-1:0] opa_reg;
    logic [WORD_W-1:0] opb_reg;

    logic [WORD_W-1:0] acc_next;
    logic [WORD_W-1:0] opa_next;
    logic [WORD_W-1:0] opb_next;
    logic [WORD_W-1:0] rem_shift;
    logic              fits;

    // one bit per cycle: shift-add for multiply, restoring step for divide
    always_comb
    begin
        rem_shift = {acc_reg[WORD_W-2:0], opa_reg[WORD_W-1]};
        fits      = (rem_shift >= opb_reg);
        if (is_div_reg)
        begin
            acc_next = fits ? (rem_shift - opb_reg) : rem_shift;
            opa_next = {opa_reg[WORD_W-2:0], fits};
            opb_next = opb_reg;
        end
        else
        begin
            acc_next = acc_reg + (opb_reg[0] ? opa_reg : '0);
            opa_next = {opa_reg[WORD_W-2:0], 1'b0};
            opb_next = {1'b0, opb_reg[WORD_W-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            is_div_reg <= req.is_div;
            neg_reg    <= a[WORD_W-1] ^ b[WORD_W-1];
            acc_reg    <= '0;
            // divide works on magnitudes, sign is restored at the end
            opa_reg    <= (req.is_div && a[WORD_W-1]) ? ('0 - a) : a;
            opb_reg    <= (req.is_div && b[WORD_W-1]) ? ('0 - b) : b;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            opa_reg <= opa_next;
            opb_reg <= opb_next;
        end
    end

    assign done   = done_reg;
    assign result = is_div_reg ? (neg_reg ? ('0 - opa_reg) : opa_reg) : acc_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("muldiv started while busy");

endmodule

[rtl/core/rpn_stack_calculator.sv]
`timescale 1ns / 1ps

// Reverse-Polish integer calculator on a stack of STACK_DEPTH 32-bit words,
// built as a row of cells with the top of stack in the first cell. Each
// request is a number to push or an operator (add, subtract, multiply,
// divide); each one yields exactly one response with a status, the new top
// (zero when empty) and the depth. One request is worked on at a time: push,
// add, subtract and any request that fails go from acceptance straight to
// the finish state and its commit into the output register; multiply and
// divide first run on the shared one-bit-per-cycle multiply/divide unit (32
// steps, then its registered done) before that commit. The next request is
// taken in the cycle after the commit, and the commit waits while the output
// is stalled. A new request is taken while the previous response still waits
// in the output register.
module rpn_stack_calculator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_item_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [FUNC_W-1:0] func_reg;
    logic [WORD_W-1:0] num_reg;
    logic              rsp_valid_reg;
    rsp_item_t         rsp_reg;

    logic [WORD_W-1:0] cell_val [STACK_DEPTH];
    cell_ctrl_t        cell_ctrl [STACK_DEPTH];

    logic              accept;
    logic              out_free;
    logic              commit;
    logic              empty;
    logic              full;
    logic              multi;
    logic              need_md;
    logic [WORD_W-1:0] op_a;
    logic [WORD_W-1:0] op_b;

    md_req_t           md_req;
    logic              md_done;
    logic [WORD_W-1:0] md_result;

    status_t           status;
    logic              do_load;
    logic              do_down;
    logic              do_up;
    logic [WORD_W-1:0] load_val;
    logic [WORD_W-1:0] new_top;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == FULL_COUNT);
    assign multi    = (count_reg > CNT_W'(1));
    assign op_b     = cell_val[0];
    assign op_a     = multi ? cell_val[1] : cell_val[0];
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign accept   = cmd_valid && !cmd_stall;
    assign need_md  = !empty && ((cmd.func == FN_MUL) ||
                                 ((cmd.func == FN_DIV) && (op_b != '0)));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (accept)
                begin
                    state_next = need_md ? CS_CALC : CS_FINISH;
                end
            end
            CS_CALC:
            begin
                if (md_done)
                begin
                    state_next = CS_FINISH;
                end
            end
            CS_FINISH:
            begin
                if (out_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        cmd_stall     = (state_reg != CS_IDLE);
        md_req.start  = (state_reg == CS_IDLE) && accept && need_md;
        md_req.is_div = (cmd.func == FN_DIV);
        commit        = (state_reg == CS_FINISH) && out_free;
    end

    // decode the held request against the current stack
    always_comb
    begin
        status     = ST_OK;
        do_load    = 1'b0;
        do_down    = 1'b0;
        do_up      = 1'b0;
        load_val   = md_result;
        count_next = count_reg;
        case (func_reg)
            FN_PUSH:
            begin
                load_val = num_reg;
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    do_load    = 1'b1;
                    do_down    = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV:
            begin
                if (func_reg == FN_ADD)
                begin
                    load_val = op_a + op_b;
                end
                else if (func_reg == FN_SUB)
                begin
                    load_val = op_a - op_b;
                end
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if ((func_reg == FN_DIV) && (op_b == '0))
                begin
                    status = ST_DIVZERO;
                end
                else
                begin
                    do_load = 1'b1;
                    do_up   = multi;
                    if (multi)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                status = ST_UNKNOWN;
            end
        endcase
        if (do_load)
        begin
            new_top = load_val;
        end
        else
        begin
            new_top = empty ? '0 : cell_val[0];
        end
    end

    // the first cell only loads; the rest shift with the chain
    always_comb
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
        begin
            cell_ctrl[i].load       = 1'b0;
            cell_ctrl[i].shift_down = commit && do_down && (i != 0);
            cell_ctrl[i].shift_up   = commit && do_up && (i != 0);
        end
        cell_ctrl[0].load = commit && do_load;
    end

    for (genvar g = 0; g < STACK_DEPTH; g++)
    begin : g_cell
        logic [WORD_W-1:0] above;
        logic [WORD_W-1:0] below;

        if (g == 0)
        begin : g_first
            assign above = '0;
        end
        else
        begin : g_mid
            assign above = cell_val[g-1];
        end

        if (g == STACK_DEPTH - 1)
        begin : g_last
            assign below = '0;
        end
        else
        begin : g_inner
            assign below = cell_val[g+1];
        end

        rpn_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[g]),
            .from_above (above),
            .from_below (below),
            .load_value (load_val),
            .value      (cell_val[g])
        );
    end

    rpn_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (md_req),
        .a      (op_a),
        .b      (op_b),
        .done   (md_done),
        .result (md_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= cmd.func;
            num_reg  <= $unsigned(cmd.number);
        end
        if (commit)
        begin
            rsp_reg.status    <= status;
            rsp_reg.top_value <= $signed(new_top);
            rsp_reg.depth     <= DEPTH_W'(count_next);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("stack count beyond depth");

    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        md_done |-> (state_reg == CS_CALC))
        else $error("muldiv result outside calc state");

    a_commit_resp: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp_valid_reg && (state_reg == CS_IDLE))
        else $error("commit did not produce a response");

endmodule
